[hw/rtl/sds_pkg.sv]
// Shared types and constants of the splat depth sorter.
package sds_pkg;

  // Store size and field widths
  localparam int unsigned SPLATS    = 256;
  localparam int unsigned OCC_W     = $clog2(SPLATS + 1);
  localparam int unsigned ID_W      = 24;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ZX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ZY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ZZ = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ZT = 2'd3;

  // Reset values of the view matrix z row (zz is 1.0 in Q16.16)
  localparam logic [DATA_W-1:0] VIEW_ZZ_RESET = 32'h0001_0000;

  // Request type codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  // One stored entry
  typedef struct packed {
    logic [DATA_W-1:0] depth;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              drn;
    logic [DATA_W-1:0] key;
    logic [ID_W-1:0]   id;
  } cell_cmd_t;

  // View matrix z row
  typedef struct packed {
    logic [DATA_W-1:0] zx;
    logic [DATA_W-1:0] zy;
    logic [DATA_W-1:0] zz;
    logic [DATA_W-1:0] zt;
  } view_cfg_t;

  // Stage enables of the depth pipeline
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic sat_en;
  } depth_ctl_t;

endpackage

[hw/rtl/sds_depth.sv]
// View depth datapath: three products, exact sum, floor shift and saturation.
module sds_depth import sds_pkg::*; (
  input  logic              clk_i,
  input  depth_ctl_t        ctl_i,
  input  view_cfg_t         cfg_i,
  input  logic [DATA_W-1:0] pos_x_i,
  input  logic [DATA_W-1:0] pos_y_i,
  input  logic [DATA_W-1:0] pos_z_i,
  output logic [DATA_W-1:0] depth_o
);

  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic [DATA_W-1:0]        depth_d, depth_q;
  logic                     in_range;

  // Multiply each coordinate by its coefficient (exact Q32.32)
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      px_q <= $signed(cfg_i.zx) * $signed(pos_x_i);
      py_q <= $signed(cfg_i.zy) * $signed(pos_y_i);
      pz_q <= $signed(cfg_i.zz) * $signed(pos_z_i);
    end
  end

  // Sum the products with the translation term aligned to Q32.32
  assign sum_d = SUM_W'(px_q) + SUM_W'(py_q) + SUM_W'(pz_q)
               + (SUM_W'($signed(cfg_i.zt)) <<< FRAC_W);

  always_ff @(posedge clk_i) begin
    if (ctl_i.add_en) begin
      sum_q <= sum_d;
    end
  end

  // Drop the low fraction bits (floor) and clamp to the 32-bit range
  assign in_range = (sum_q[SUM_W-1:FRAC_W+DATA_W-1] == '0) ||
                    (sum_q[SUM_W-1:FRAC_W+DATA_W-1] == '1);

  always_comb begin
    if (in_range) begin
      depth_d = sum_q[FRAC_W+DATA_W-1:FRAC_W];
    end else if (sum_q[SUM_W-1]) begin
      depth_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      depth_d = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sat_en) begin
      depth_q <= depth_d;
    end
  end

  assign depth_o = depth_q;

endmodule

[hw/rtl/sds_cell.sv]
// One cell of the sorted chain: holds an entry and shifts it on insert or drain.
module sds_cell import sds_pkg::*; (
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      occupied_i,
  input  logic      left_gt_i,
  input  entry_t    left_i,
  input  entry_t    right_i,
  output logic      gt_o,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;

  // An empty cell counts as deeper than any key, ties stay in front
  assign gt_o = !occupied_i || ($signed(entry_q.depth) > $signed(cmd_i.key));

  // Take the new entry at the first deeper slot, shift the rest right
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins && gt_o) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else begin
        entry_d.depth = cmd_i.key;
        entry_d.id    = cmd_i.id;
      end
    end else if (cmd_i.drn) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[hw/rtl/splat_depth_sorter_top.sv]
// Top level of the splat depth sorter: control, configuration, cell chain, output.
//
// Usage: requests enter on in_valid_i / in_stall_o; req_type_i selects insert
// (splat_id_i and pos_*_i give the splat) or drain (fields ignored). Every
// request yields exactly one result on out_valid_o / out_stall_i.
// An insert computes the view depth and places the splat in a chain of
// SPLATS cells kept in ascending depth order, equal depths in arrival order;
// a full chain drops it and flags overflow_o. A drain removes the nearest
// entry, with is_last_o set when the chain becomes empty.
// Timing: a request is taken only in the idle state, then passes product,
// sum, clamp and chain-update cycles; the result register loads in the
// chain-update cycle and the next request is taken in the cycle after, so
// no request is accepted before the previous one is through. The three-stage
// depth datapath and the chain update in its own cycle set the request spacing.
// Reset empties the chain (count of entries goes to zero) and loads the view
// row with zx = zy = zt = 0 and zz = 1.0; there is no clearing pass.
// When the receiver stalls, the result holds; a following request may still
// be accepted and computed, but waits in the chain-update cycle until the
// result register is free.
// Configuration writes are taken in any cycle and must come while idle.
module splat_depth_sorter_top import sds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  // Requests
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [ID_W-1:0]      splat_id_i,
  input  logic [DATA_W-1:0]    pos_x_i,
  input  logic [DATA_W-1:0]    pos_y_i,
  input  logic [DATA_W-1:0]    pos_z_i,
  // Results
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ID_W-1:0]      out_id_o,
  output logic [DATA_W-1:0]    out_depth_o,
  output logic                 valid_res_o,
  output logic                 is_last_o,
  output logic                 overflow_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ADD   = 4'b0010,
    ST_SAT   = 4'b0100,
    ST_APPLY = 4'b1000
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] depth;
    logic              valid_res;
    logic              is_last;
    logic              overflow;
  } result_t;

  state_e            state_q, state_d;
  view_cfg_t         cfg_q;
  logic              req_type_q;
  logic [ID_W-1:0]   id_q;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;
  logic              accept;
  logic              apply;
  logic              full;
  logic              empty;
  depth_ctl_t        depth_ctl;
  logic [DATA_W-1:0] depth;
  cell_cmd_t         cmd;
  logic              gt   [SPLATS];
  entry_t            cells[SPLATS];

  // Write the view row registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zx <= '0;
      cfg_q.zy <= '0;
      cfg_q.zz <= VIEW_ZZ_RESET;
      cfg_q.zt <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VIEW_ZX: cfg_q.zx <= cfg_data_i;
        CFG_VIEW_ZY: cfg_q.zy <= cfg_data_i;
        CFG_VIEW_ZZ: cfg_q.zz <= cfg_data_i;
        CFG_VIEW_ZT: cfg_q.zt <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake and store status
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign apply      = (state_q == ST_APPLY) && !(out_valid_q && out_stall_i);
  assign full       = (occ_q == OCC_W'(SPLATS));
  assign empty      = (occ_q == '0);

  // Sequence one request through the datapath
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_ADD;
      ST_ADD:   state_d = ST_SAT;
      ST_SAT:   state_d = ST_APPLY;
      ST_APPLY: if (apply) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_type_i;
      id_q       <= splat_id_i;
    end
  end

  // Depth datapath
  assign depth_ctl.mul_en = accept;
  assign depth_ctl.add_en = (state_q == ST_ADD);
  assign depth_ctl.sat_en = (state_q == ST_SAT);

  sds_depth u_depth (
    .clk_i   (clk_i),
    .ctl_i   (depth_ctl),
    .cfg_i   (cfg_q),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .pos_z_i (pos_z_i),
    .depth_o (depth)
  );

  // Broadcast the command to the chain
  assign cmd.ins = apply && (req_type_q == REQ_INSERT) && !full;
  assign cmd.drn = apply && (req_type_q == REQ_DRAIN) && !empty;
  assign cmd.key = depth;
  assign cmd.id  = id_q;

  for (genvar i = 0; i < SPLATS; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_gt;
    logic   occupied;

    assign occupied = (OCC_W'(i) < occ_q);

    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_e  = cells[i-1];
      assign left_gt = gt[i-1];
    end

    if (i == SPLATS - 1) begin : g_tail
      assign right_e = cells[i];
    end else begin : g_inner
      assign right_e = cells[i+1];
    end

    sds_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occupied_i (occupied),
      .left_gt_i  (left_gt),
      .left_i     (left_e),
      .right_i    (right_e),
      .gt_o       (gt[i]),
      .entry_o    (cells[i])
    );
  end

  // Track the entry count
  always_comb begin
    occ_d = occ_q;
    if (cmd.ins) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (cmd.drn) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Build the result
  always_comb begin
    out_d = '0;
    if (req_type_q == REQ_INSERT) begin
      out_d.id        = id_q;
      out_d.depth     = depth;
      out_d.valid_res = !full;
      out_d.overflow  = full;
    end else if (!empty) begin
      out_d.id        = cells[0].id;
      out_d.depth     = cells[0].depth;
      out_d.valid_res = 1'b1;
      out_d.is_last   = (occ_q == OCC_W'(1));
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (apply) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_q.id;
  assign out_depth_o = out_q.depth;
  assign valid_res_o = out_q.valid_res;
  assign is_last_o   = out_q.is_last;
  assign overflow_o  = out_q.overflow;

endmodule

[tb/tb_top.sv]
// Self-checking testbench of splat_depth_sorter_top against a sorted-store predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sds_pkg::*;

  localparam int TOTAL_REQS = 1870;
  localparam int QUIET_FROM = TOTAL_REQS - 200;

  // One result as the block reports it
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] depth;
    logic              ok;
    logic              last;
    logic              ovf;
  } sort_result_t;

  // Depth predictor with its own copy of the view row and of the sorted store
  class depth_sort_scoreboard;
    logic signed [DATA_W-1:0] zx, zy, zz, zt;
    logic signed [DATA_W-1:0] near_to_far_depth[$];
    logic [ID_W-1:0]          near_to_far_id[$];
    sort_result_t             due_results[$];
    int                       errors;

    function new();
      zx = '0;
      zy = '0;
      zz = VIEW_ZZ_RESET;
      zt = '0;
      errors = 0;
    endfunction

    function void set_view(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_VIEW_ZX: zx = data;
        CFG_VIEW_ZY: zy = data;
        CFG_VIEW_ZZ: zz = data;
        CFG_VIEW_ZT: zt = data;
        default: ;
      endcase
    endfunction

    function int occupancy();
      return near_to_far_depth.size();
    endfunction

    // Exact Q32.32 sum, floor to Q16.16, clamp to 32 bits
    function logic signed [DATA_W-1:0] view_depth(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                                                  logic [DATA_W-1:0] z);
      logic signed [67:0] ezx, ezy, ezz, ezt, ex, ey, ez, acc, sh;
      ezx = zx;
      ezy = zy;
      ezz = zz;
      ezt = zt;
      ex = $signed(x);
      ey = $signed(y);
      ez = $signed(z);
      acc = ezx * ex + ezy * ey + ezz * ez + (ezt <<< 16);
      sh = acc >>> 16;
      if (sh > 68'sd2147483647) return 32'h7FFF_FFFF;
      if (sh < -68'sd2147483648) return 32'h8000_0000;
      return sh[DATA_W-1:0];
    endfunction

    // Apply an accepted request to the store and queue its result
    function void note_request(logic kind, logic [ID_W-1:0] id, logic [DATA_W-1:0] x,
                               logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
      sort_result_t             r;
      logic signed [DATA_W-1:0] d;
      int                       pos;
      r = '0;
      if (kind == REQ_INSERT) begin
        d = view_depth(x, y, z);
        r.id = id;
        r.depth = d;
        if (near_to_far_depth.size() >= SPLATS) begin
          r.ovf = 1'b1;
        end else begin
          // Equal depths keep arrival order: go after every equal entry
          pos = near_to_far_depth.size();
          while (pos > 0 && near_to_far_depth[pos-1] > d) pos--;
          near_to_far_depth.insert(pos, d);
          near_to_far_id.insert(pos, id);
          r.ok = 1'b1;
        end
      end else if (near_to_far_depth.size() > 0) begin
        r.id = near_to_far_id.pop_front();
        r.depth = near_to_far_depth.pop_front();
        r.ok = 1'b1;
        r.last = (near_to_far_depth.size() == 0);
      end
      due_results.insert(due_results.size(), r);
    endfunction

    function void check_result(logic [ID_W-1:0] id, logic [DATA_W-1:0] depth, logic ok,
                               logic last, logic ovf);
      sort_result_t got, want;
      got = {id, depth, ok, last, ovf};
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result id=%h depth=%h valid=%b last=%b ovf=%b",
                   $realtime, id, depth, ok, last, ovf);
        return;
      end
      want = due_results.pop_front();
      if (got.id !== want.id || got.depth !== want.depth || got.ok !== want.ok ||
          got.last !== want.last || got.ovf !== want.ovf) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: mismatch, expected id=%h depth=%h valid=%b last=%b ovf=%b,",
                    " got id=%h depth=%h valid=%b last=%b ovf=%b"},
                   $realtime, want.id, want.depth, want.ok, want.last, want.ovf,
                   got.id, got.depth, got.ok, got.last, got.ovf);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_VIEW_ZX;
  logic [DATA_W-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i  = REQ_INSERT;
  logic [ID_W-1:0]      splat_id_i  = '0;
  logic [DATA_W-1:0]    pos_x_i     = '0;
  logic [DATA_W-1:0]    pos_y_i     = '0;
  logic [DATA_W-1:0]    pos_z_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [ID_W-1:0]      out_id_o;
  logic [DATA_W-1:0]    out_depth_o;
  logic                 valid_res_o;
  logic                 is_last_o;
  logic                 overflow_o;

  depth_sort_scoreboard sb;
  bit                   src_idle_on  = 1'b1;
  bit                   sink_idle_on = 1'b1;
  int                   reqs_sent    = 0;
  logic [DATA_W-1:0]    last_x = '0, last_y = '0, last_z = '0;

  splat_depth_sorter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .splat_id_i  (splat_id_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_id_o    (out_id_o),
    .out_depth_o (out_depth_o),
    .valid_res_o (valid_res_o),
    .is_last_o   (is_last_o),
    .overflow_o  (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[splat_depth_sorter_top] ERROR");
    $finish;
  end

  // Check every result taken by the receiver
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(out_id_o, out_depth_o, valid_res_o, is_last_o, overflow_o);
  end

  // Stall the result side in random bursts
  initial begin
    forever begin
      if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
    end
  end

  // Present one request and hold it until it is accepted
  task automatic send_req(input logic kind, input logic [ID_W-1:0] id,
                          input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                          input logic [DATA_W-1:0] z);
    if (reqs_sent >= QUIET_FROM) begin
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
    end
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    splat_id_i <= id;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, id, x, y, z);
    reqs_sent++;
  endtask

  function automatic logic [DATA_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return 32'((int'($urandom_range(0, 4)) - 2) * 65536);
      7:          return 32'h8000_0000;
      8:          return 32'h7FFF_FFFF;
      default:    return 32'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return ID_W'($urandom);
    endcase
  endfunction

  // Insert, often at the previous position to force equal depths
  task automatic send_insert();
    if ($urandom_range(0, 99) >= 15) begin
      last_x = pick_coord();
      last_y = pick_coord();
      last_z = pick_coord();
    end
    send_req(REQ_INSERT, pick_id(), last_x, last_y, last_z);
  endtask

  task automatic send_drain();
    send_req(REQ_DRAIN, ID_W'($urandom), $urandom, $urandom, $urandom);
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the whole view row, one register per cycle
  task automatic write_view_row(input logic [DATA_W-1:0] vzx, input logic [DATA_W-1:0] vzy,
                                input logic [DATA_W-1:0] vzz, input logic [DATA_W-1:0] vzt);
    logic [DATA_W-1:0]    vals[4];
    logic [CFG_IDX_W-1:0] regs[4];
    vals[0] = vzx;
    vals[1] = vzy;
    vals[2] = vzz;
    vals[3] = vzt;
    regs[0] = CFG_VIEW_ZX;
    regs[1] = CFG_VIEW_ZY;
    regs[2] = CFG_VIEW_ZZ;
    regs[3] = CFG_VIEW_ZT;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_view(regs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_coeff();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] small_coeff();
    return 32'(int'($urandom_range(0, 262144)) - 131072);
  endfunction

  task automatic pick_view(input int mode);
    case (mode)
      0: write_view_row('0, '0, VIEW_ZZ_RESET, '0);
      1: write_view_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      2: write_view_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      3: write_view_row($urandom, $urandom, $urandom, $urandom);
      4: write_view_row(small_coeff(), small_coeff(), small_coeff(), small_coeff());
      5: write_view_row('0, '0, small_coeff(), $urandom);
      default: write_view_row(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
    endcase
  endtask

  // Short hand-picked sequence: empty drains, extremes, ties, saturation, floor rounding
  task automatic run_directed();
    send_drain();
    send_req(REQ_INSERT, '0, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_req(REQ_INSERT, '1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_req(REQ_INSERT, 24'h123456, '1, '0, 32'h8000_0000);
    send_req(REQ_INSERT, 24'h00000A, '0, '1, '0);
    repeat (5) send_drain();
    settle();
    write_view_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_req(REQ_INSERT, 24'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_req(REQ_INSERT, 24'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    repeat (2) send_drain();
    settle();
    write_view_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_req(REQ_INSERT, 24'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_req(REQ_INSERT, 24'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    repeat (2) send_drain();
    settle();
    // Tiny negative products must round toward minus infinity
    write_view_row('1, '0, '0, '0);
    send_req(REQ_INSERT, 24'd5, 32'd1, $urandom, $urandom);
    send_req(REQ_INSERT, 24'd6, '1, $urandom, $urandom);
    repeat (2) send_drain();
  endtask

  // Fill past capacity, then empty the store and drain it once more
  task automatic fill_then_empty();
    while (sb.occupancy() < SPLATS) begin
      if (sb.occupancy() > 0 && $urandom_range(0, 9) == 0) send_drain();
      else send_insert();
    end
    repeat ($urandom_range(3, 8)) send_insert();
    while (sb.occupancy() > 0) begin
      if ($urandom_range(0, 9) == 0) send_insert();
      else send_drain();
    end
    repeat ($urandom_range(1, 3)) send_drain();
  endtask

  // Random mix of inserts and drains with a per-round bias
  task automatic churn_round();
    int n;
    int ins_pct;
    n = $urandom_range(100, 200);
    ins_pct = $urandom_range(30, 75);
    repeat (n) begin
      if ($urandom_range(1, 100) <= ins_pct) send_insert();
      else send_drain();
    end
  endtask

  initial begin
    int round;
    sb = new();
    round = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    while (reqs_sent < TOTAL_REQS) begin
      settle();
      pick_view(round % 7);
      src_idle_on = (reqs_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      sink_idle_on = (reqs_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if (round % 4 == 1) fill_then_empty();
      else churn_round();
      round++;
    end

    // Drain outstanding results and let the block go quiet
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[splat_depth_sorter_top] OK");
    end else begin
      $display("[splat_depth_sorter_top] ERROR");
    end
    $finish;
  end

endmodule
